// ===== src/indexed_line_pixel_render_unit_macros.svh =====
// assertion helpers for the line render unit
`ifndef INDEXED_LINE_PIXEL_RENDER_UNIT_MACROS_SVH
`define INDEXED_LINE_PIXEL_RENDER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ILPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilpr check failed");

// next-cycle implication, quiet during reset
`define ILPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilpr check failed");

`endif

// ===== src/ilpr_pkg.sv =====
`timescale 1ns / 1ps
package ilpr_pkg;

    localparam int CANVAS_W      = 256;
    localparam int CANVAS_H      = 256;
    localparam int PALETTE_DEPTH = 256;

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W = 16;
    localparam int POS_W   = 12;
    localparam int OFS_W   = 10;
    localparam int COORD_W = 16;
    localparam int OUT_W   = 8;
    localparam int CFG_W   = 10;

    localparam logic [1:0] ACT_PALETTE = 2'd0;
    localparam logic [1:0] ACT_LINE    = 2'd1;
    localparam logic [1:0] ACT_PIXEL   = 2'd2;

    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE    = 2'd2;

    // one pixel ready for the write generator: base position and which of
    // the 2x2 writes land on the canvas, bit order (x,y) (x+1,y) (x,y+1) (x+1,y+1)
    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [3:0]       mask;
    } pix_cmd_t;

    typedef struct packed {
        logic s1_valid;
        logic em_busy;
    } em_status_t;

endpackage

// ===== src/indexed_line_pixel_render_unit.sv =====
// path: a pixel beat passes the s1 stage, the em stage and the output register
// throughput: one canvas write per cycle from the output register while out_stall
//   is low; a pixel gives one write unscaled and up to four with 2x2 scaling;
//   palette and line-start beats give no write
// reset: control, config and line state clear; palette memory is not cleared
//   and holds garbage until written
`timescale 1ns / 1ps
`include "indexed_line_pixel_render_unit_macros.svh"
module indexed_line_pixel_render_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [ilpr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [7:0]                        color_index,
    input  logic [ilpr_pkg::COLOR_W-1:0]      palette_color,
    input  logic [ilpr_pkg::POS_W-1:0]        frame_x,
    input  logic [ilpr_pkg::POS_W-1:0]        line_y,
    input  logic [ilpr_pkg::POS_W-1:0]        line_width,
    input  logic [7:0]                        transparent_index,
    input  logic [7:0]                        background_index,
    input  logic                              dispose_background,
    input  logic                              has_transparency,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ilpr_pkg::OUT_W-1:0]        canvas_x,
    output logic [ilpr_pkg::OUT_W-1:0]        canvas_y,
    output logic [ilpr_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              last_write
);

    logic                             take;
    logic                             pal_we;
    logic [ilpr_pkg::PAL_AW-1:0]      pal_waddr;
    logic [ilpr_pkg::COLOR_W-1:0]     pal_wdata;
    logic                             pal_re;
    logic [ilpr_pkg::PAL_AW-1:0]      pal_raddr;
    logic [ilpr_pkg::COLOR_W-1:0]     pal_rdata;
    logic                             push;
    ilpr_pkg::pix_cmd_t               cmd;
    logic                             busy;
    ilpr_pkg::em_status_t             status;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    ilpr_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .take               (take),
        .action             (action),
        .color_index        (color_index),
        .palette_color      (palette_color),
        .frame_x            (frame_x),
        .line_y             (line_y),
        .line_width         (line_width),
        .transparent_index  (transparent_index),
        .background_index   (background_index),
        .dispose_background (dispose_background),
        .has_transparency   (has_transparency),
        .pal_we             (pal_we),
        .pal_waddr          (pal_waddr),
        .pal_wdata          (pal_wdata),
        .pal_re             (pal_re),
        .pal_raddr          (pal_raddr),
        .push               (push),
        .cmd                (cmd)
    );

    ilpr_palette_ram u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    ilpr_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .cmd         (cmd),
        .rd_color    (pal_rdata),
        .busy        (busy),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .canvas_x    (canvas_x),
        .canvas_y    (canvas_y),
        .pixel_color (pixel_color),
        .last_write  (last_write)
    );

    // a waiting pixel moves into an idle write generator right away
    `ILPR_ASSERT_NEXT(a_s1_drains, status.s1_valid && !status.em_busy, status.em_busy)
    // input only backs up behind a pixel parked on its palette read
    `ILPR_ASSERT_NOW(a_stall_cause, in_stall, status.s1_valid)
    // a taken write that is not the last one is followed by the next write
    `ILPR_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !last_write, out_valid)

endmodule

// ===== src/ilpr_palette_ram.sv =====
`timescale 1ns / 1ps
module ilpr_palette_ram (
    input  logic                               clk,
    input  logic                               we,
    input  logic [ilpr_pkg::PAL_AW-1:0]        waddr,
    input  logic [ilpr_pkg::COLOR_W-1:0]       wdata,
    input  logic                               re,
    input  logic [ilpr_pkg::PAL_AW-1:0]        raddr,
    output logic [ilpr_pkg::COLOR_W-1:0]       rdata
);

    logic [ilpr_pkg::COLOR_W-1:0] mem [ilpr_pkg::PALETTE_DEPTH];
    logic [ilpr_pkg::COLOR_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== src/ilpr_front.sv =====
`timescale 1ns / 1ps
module ilpr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [ilpr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              take,
    input  logic [1:0]                        action,
    input  logic [7:0]                        color_index,
    input  logic [ilpr_pkg::COLOR_W-1:0]      palette_color,
    input  logic [ilpr_pkg::POS_W-1:0]        frame_x,
    input  logic [ilpr_pkg::POS_W-1:0]        line_y,
    input  logic [ilpr_pkg::POS_W-1:0]        line_width,
    input  logic [7:0]                        transparent_index,
    input  logic [7:0]                        background_index,
    input  logic                              dispose_background,
    input  logic                              has_transparency,
    output logic                              pal_we,
    output logic [ilpr_pkg::PAL_AW-1:0]       pal_waddr,
    output logic [ilpr_pkg::COLOR_W-1:0]      pal_wdata,
    output logic                              pal_re,
    output logic [ilpr_pkg::PAL_AW-1:0]       pal_raddr,
    output logic                              push,
    output ilpr_pkg::pix_cmd_t                cmd
);

    logic [ilpr_pkg::OFS_W-1:0]   offset_x_reg;
    logic [ilpr_pkg::OFS_W-1:0]   offset_y_reg;
    logic                         scale_reg;
    logic [ilpr_pkg::POS_W-1:0]   origin_reg;
    logic [ilpr_pkg::POS_W-1:0]   row_reg;
    logic [ilpr_pkg::POS_W-1:0]   length_reg;
    logic [ilpr_pkg::POS_W-1:0]   column_reg;
    logic [ilpr_pkg::POS_W-1:0]   column_next;
    logic [7:0]                   t_idx_reg;
    logic [7:0]                   b_idx_reg;
    logic                         dispose_reg;
    logic                         transp_reg;

    logic                         is_pixel;
    logic                         in_line;
    logic                         is_transp;
    logic                         skip;
    logic [7:0]                   idx;
    logic [ilpr_pkg::COORD_W-1:0] x_raw;
    logic [ilpr_pkg::COORD_W-1:0] y_raw;
    logic [ilpr_pkg::COORD_W-1:0] xs;
    logic [ilpr_pkg::COORD_W-1:0] ys;
    logic [ilpr_pkg::COORD_W-1:0] x1;
    logic [ilpr_pkg::COORD_W-1:0] y1;
    logic                         x0_in;
    logic                         x1_in;
    logic                         y0_in;
    logic                         y1_in;

    always_comb
    begin
        is_pixel  = take && (action == ilpr_pkg::ACT_PIXEL);
        in_line   = column_reg < length_reg;
        is_transp = color_index == t_idx_reg;
        skip      = !dispose_reg && transp_reg && is_transp;
        idx       = (dispose_reg && is_transp) ? b_idx_reg : color_index;

        x_raw = ilpr_pkg::COORD_W'(offset_x_reg) + ilpr_pkg::COORD_W'(origin_reg)
              + ilpr_pkg::COORD_W'(column_reg);
        y_raw = ilpr_pkg::COORD_W'(offset_y_reg) + ilpr_pkg::COORD_W'(row_reg);
        xs    = scale_reg ? {x_raw[ilpr_pkg::COORD_W-2:0], 1'b0} : x_raw;
        ys    = scale_reg ? {y_raw[ilpr_pkg::COORD_W-2:0], 1'b0} : y_raw;
        x1    = xs + ilpr_pkg::COORD_W'(1);
        y1    = ys + ilpr_pkg::COORD_W'(1);
        x0_in = xs < ilpr_pkg::COORD_W'(ilpr_pkg::CANVAS_W);
        x1_in = x1 < ilpr_pkg::COORD_W'(ilpr_pkg::CANVAS_W);
        y0_in = ys < ilpr_pkg::COORD_W'(ilpr_pkg::CANVAS_H);
        y1_in = y1 < ilpr_pkg::COORD_W'(ilpr_pkg::CANVAS_H);

        cmd.x       = xs[ilpr_pkg::OUT_W-1:0];
        cmd.y       = ys[ilpr_pkg::OUT_W-1:0];
        cmd.mask[0] = x0_in && y0_in;
        cmd.mask[1] = scale_reg && x1_in && y0_in;
        cmd.mask[2] = scale_reg && x0_in && y1_in;
        cmd.mask[3] = scale_reg && x1_in && y1_in;

        // column advances even for skipped or off-canvas pixels
        column_next = column_reg;
        if (take && (action == ilpr_pkg::ACT_LINE))
        begin
            column_next = '0;
        end
        else if (is_pixel && in_line)
        begin
            column_next = column_reg + ilpr_pkg::POS_W'(1);
        end

        push      = is_pixel && in_line && !skip && (cmd.mask != 4'd0);
        pal_re    = push;
        pal_raddr = ilpr_pkg::PAL_AW'(idx);
        pal_we    = take && (action == ilpr_pkg::ACT_PALETTE)
                 && (ilpr_pkg::PAL_AW'(color_index) == color_index);
        pal_waddr = ilpr_pkg::PAL_AW'(color_index);
        pal_wdata = palette_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            scale_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ilpr_pkg::CFG_OFFSET_X: offset_x_reg <= cfg_data;
                ilpr_pkg::CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                ilpr_pkg::CFG_SCALE:    scale_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            row_reg     <= '0;
            length_reg  <= '0;
            column_reg  <= '0;
            t_idx_reg   <= '0;
            b_idx_reg   <= '0;
            dispose_reg <= 1'b0;
            transp_reg  <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            if (take && (action == ilpr_pkg::ACT_LINE))
            begin
                origin_reg  <= frame_x;
                row_reg     <= line_y;
                length_reg  <= line_width;
                t_idx_reg   <= transparent_index;
                b_idx_reg   <= background_index;
                dispose_reg <= dispose_background;
                transp_reg  <= has_transparency;
            end
        end
    end

endmodule

// ===== src/ilpr_emitter.sv =====
`timescale 1ns / 1ps
module ilpr_emitter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  ilpr_pkg::pix_cmd_t                cmd,
    input  logic [ilpr_pkg::COLOR_W-1:0]      rd_color,
    output logic                              busy,
    output ilpr_pkg::em_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ilpr_pkg::OUT_W-1:0]        canvas_x,
    output logic [ilpr_pkg::OUT_W-1:0]        canvas_y,
    output logic [ilpr_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              last_write
);

    // s1: pixel waiting for its palette read; em: pixel being expanded
    logic                         s1_valid_reg;
    ilpr_pkg::pix_cmd_t           s1_cmd_reg;
    logic [3:0]                   em_mask_reg;
    logic [3:0]                   em_mask_next;
    logic [ilpr_pkg::OUT_W-1:0]   em_x_reg;
    logic [ilpr_pkg::OUT_W-1:0]   em_y_reg;
    logic [ilpr_pkg::COLOR_W-1:0] em_color_reg;
    logic                         out_valid_reg;
    logic [ilpr_pkg::OUT_W-1:0]   canvas_x_reg;
    logic [ilpr_pkg::OUT_W-1:0]   canvas_y_reg;
    logic [ilpr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                         last_write_reg;

    logic                         out_free;
    logic                         fire;
    logic [3:0]                   low_bit;
    logic [3:0]                   mask_rest;
    logic                         em_load;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        fire      = (em_mask_reg != 4'd0) && out_free;
        low_bit   = em_mask_reg & (~em_mask_reg + 4'd1);
        mask_rest = em_mask_reg & ~low_bit;
        em_load   = s1_valid_reg && ((fire ? mask_rest : em_mask_reg) == 4'd0);

        em_mask_next = em_mask_reg;
        if (em_load)
        begin
            em_mask_next = s1_cmd_reg.mask;
        end
        else if (fire)
        begin
            em_mask_next = mask_rest;
        end

        busy            = s1_valid_reg && !em_load;
        status.s1_valid = s1_valid_reg;
        status.em_busy  = em_mask_reg != 4'd0;
        out_valid       = out_valid_reg;
        canvas_x        = canvas_x_reg;
        canvas_y        = canvas_y_reg;
        pixel_color     = pixel_color_reg;
        last_write      = last_write_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            em_mask_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            em_mask_reg <= em_mask_next;
            if (push)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (em_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_cmd_reg <= cmd;
        end
        if (em_load)
        begin
            em_x_reg     <= s1_cmd_reg.x;
            em_y_reg     <= s1_cmd_reg.y;
            em_color_reg <= rd_color;
        end
        if (fire)
        begin
            canvas_x_reg    <= em_x_reg + ilpr_pkg::OUT_W'(low_bit[1] | low_bit[3]);
            canvas_y_reg    <= em_y_reg + ilpr_pkg::OUT_W'(low_bit[2] | low_bit[3]);
            pixel_color_reg <= em_color_reg;
            last_write_reg  <= mask_rest == 4'd0;
        end
    end

endmodule
